### sv/tmr_tbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_tbl_pkg
// Shared widths, codes and structs for the timer table with scheduler tick.
// ----------------------------------------------------------------------------
package tmr_tbl_pkg;

    localparam int NOW_W        = 48;
    localparam int MS_W         = 24;
    localparam int TPM_W        = 20;
    localparam int TAG_W        = 16;
    localparam int PERIOD_W     = MS_W + TPM_W;
    localparam int DL_W         = NOW_W + 1;
    localparam int TT_NUM_SLOTS = 16;

    localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

    typedef enum logic [1:0] {
        CMD_TICK         = 2'd0,
        CMD_ADD_ONCE     = 2'd1,
        CMD_ADD_PERIODIC = 2'd2,
        CMD_INSTALL      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_SCHED     = 3'd1,
        KIND_ASSIGNED  = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_INSTALLED = 3'd4
    } kind_t;

    // fields of the transaction in flight, shared by every cell
    typedef struct packed {
        cmd_t                cmd;
        logic [NOW_W-1:0]    now;
        logic [PERIOD_W-1:0] period;
        logic [TAG_W-1:0]    tag;
    } bcast_t;

    // result offered by a cell or by the scheduler stage
    typedef struct packed {
        logic             valid;
        kind_t            kind;
        logic [TAG_W-1:0] tag;
    } cand_t;

endpackage : tmr_tbl_pkg
`default_nettype wire

### sv/tmr_tbl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_tbl_cell
// One timer slot. A token walks the row; the cell acts in its token cycle.
// ----------------------------------------------------------------------------
module tmr_tbl_cell
    import tmr_tbl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   tok_in,
    input  wire logic   claim_in,
    input  wire bcast_t bcast,
    output logic        tok_out,
    output logic        claim_out,
    output cand_t       cand
);

    logic                valid_reg, valid_next;
    logic                periodic_reg, periodic_next;
    logic [DL_W-1:0]     deadline_reg, deadline_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                tok_reg;
    logic                claim_reg;

    logic            is_add;
    logic            fire;
    logic            take;
    logic [DL_W-1:0] now_ext;
    logic [DL_W-1:0] reload;

    // fire and claim decisions
    always_comb
    begin
        is_add  = (bcast.cmd == CMD_ADD_ONCE) || (bcast.cmd == CMD_ADD_PERIODIC);
        now_ext = {1'b0, bcast.now};
        fire    = tok_in && valid_reg && (bcast.cmd == CMD_TICK) && (deadline_reg <= now_ext);
        take    = tok_in && is_add && !claim_in && !valid_reg;
    end

    // own reload sum, never wraps
    always_comb
    begin
        reload = now_ext + DL_W'(bcast.period);
    end

    // next slot contents, add and fire never meet in one transaction
    always_comb
    begin
        valid_next    = valid_reg;
        periodic_next = periodic_reg;
        deadline_next = deadline_reg;
        period_next   = period_reg;
        tag_next      = tag_reg;
        if (take)
        begin
            valid_next    = 1'b1;
            periodic_next = (bcast.cmd == CMD_ADD_PERIODIC);
            deadline_next = reload;
            period_next   = bcast.period;
            tag_next      = bcast.tag;
        end
        else if (fire)
        begin
            if (periodic_reg)
            begin
                deadline_next = now_ext + DL_W'(period_reg);
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // result offered this cycle
    always_comb
    begin
        cand.valid = fire || take;
        cand.kind  = take ? KIND_ASSIGNED : KIND_FIRED;
        cand.tag   = take ? bcast.tag : tag_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            periodic_reg <= 1'b0;
            tok_reg      <= 1'b0;
            claim_reg    <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            periodic_reg <= periodic_next;
            tok_reg      <= tok_in;
            claim_reg    <= claim_in || take;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        period_reg   <= period_next;
        tag_reg      <= tag_next;
    end

    assign tok_out   = tok_reg;
    assign claim_out = claim_reg;

endmodule : tmr_tbl_cell
`default_nettype wire

### sv/tmr_tbl_sched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_tbl_sched
// Scheduler deadline stage at the end of the row, plus table-full report.
// ----------------------------------------------------------------------------
module tmr_tbl_sched
    import tmr_tbl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   tok_in,
    input  wire logic   claim_in,
    input  wire bcast_t bcast,
    output logic        flush,
    output cand_t       cand
);

    logic                installed_reg, installed_next;
    logic [DL_W-1:0]     deadline_reg, deadline_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                flush_reg;

    logic            is_add;
    logic            fire;
    logic            install;
    logic            full;
    logic [DL_W-1:0] now_ext;

    // decisions for this transaction
    always_comb
    begin
        is_add  = (bcast.cmd == CMD_ADD_ONCE) || (bcast.cmd == CMD_ADD_PERIODIC);
        now_ext = {1'b0, bcast.now};
        fire    = tok_in && installed_reg && (bcast.cmd == CMD_TICK)
                  && (deadline_reg <= now_ext);
        install = tok_in && (bcast.cmd == CMD_INSTALL);
        full    = tok_in && is_add && !claim_in;
    end

    // next scheduler state, install and fire never meet in one transaction
    always_comb
    begin
        installed_next = installed_reg;
        deadline_next  = deadline_reg;
        period_next    = period_reg;
        if (install)
        begin
            installed_next = 1'b1;
            period_next    = bcast.period;
            deadline_next  = now_ext + DL_W'(bcast.period);
        end
        else if (fire)
        begin
            deadline_next = now_ext + DL_W'(period_reg);
        end
    end

    // result offered this cycle
    always_comb
    begin
        cand.valid = fire || install || full;
        cand.tag   = full ? bcast.tag : '0;
        priority if (install)
        begin
            cand.kind = KIND_INSTALLED;
        end
        else if (full)
        begin
            cand.kind = KIND_FULL;
        end
        else
        begin
            cand.kind = KIND_SCHED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            installed_reg <= 1'b0;
            deadline_reg  <= '0;
            period_reg    <= '0;
            flush_reg     <= 1'b0;
        end
        else
        begin
            installed_reg <= installed_next;
            deadline_reg  <= deadline_next;
            period_reg    <= period_next;
            flush_reg     <= tok_in;
        end
    end

    assign flush = flush_reg;

endmodule : tmr_tbl_sched
`default_nettype wire

### sv/timer_table_with_scheduler_tick_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timer_table_with_scheduler_tick_top
// Table of NUM_SLOTS timers held in a row of cells, with one scheduler deadline.
// ----------------------------------------------------------------------------
// Every transaction walks a token through the whole row: first the period
// multiply, then each cell in turn, then the scheduler stage, then the flush.
// busy stays high until the flush, and no new start is taken while busy; the
// last result is strobed as busy falls.
// Results are strobed for one cycle each and cannot be held off.
// Reset clears all slots and the scheduler; the tick rate register returns to 1000.
module timer_table_with_scheduler_tick_top
    import tmr_tbl_pkg::*;
#(
    parameter int  NUM_SLOTS = TT_NUM_SLOTS,
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        command,
    input  wire logic [NOW_W-1:0]  now,
    input  wire logic [MS_W-1:0]   interval_ms,
    input  wire logic [TAG_W-1:0]  tag,
    input  wire logic              cfg_wr_en,
    input  wire logic [TPM_W-1:0]  cfg_wr_data,
    output logic                   result_valid,
    output logic [2:0]             kind,
    output logic [SLOT_W-1:0]      slot,
    output logic [TAG_W-1:0]       fired_tag,
    output logic                   last
);

    logic                busy_reg;
    logic                mul_reg;
    logic                launch_reg;
    logic [TPM_W-1:0]    tpm_reg;
    cmd_t                cmd_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [PERIOD_W-1:0] period_reg, period_next;

    logic                hold_valid_reg;
    kind_t               hold_kind_reg;
    logic [SLOT_W-1:0]   hold_slot_reg;
    logic [TAG_W-1:0]    hold_tag_reg;

    logic                result_valid_reg;
    kind_t               kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TAG_W-1:0]    fired_tag_reg;
    logic                last_reg;

    logic                accept;
    bcast_t              bcast;
    logic [NUM_SLOTS:0]  tok;
    logic [NUM_SLOTS:0]  claim;
    cand_t               cell_cand [NUM_SLOTS];
    cand_t               sched_cand;
    logic                flush;
    cand_t               cand;
    logic [SLOT_W-1:0]   cand_slot;
    logic                emit;
    logic                emit_last;

    assign accept = start && !busy_reg;

    // control of the transaction in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            mul_reg    <= 1'b0;
            launch_reg <= 1'b0;
            tpm_reg    <= TPM_RESET;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (flush)
            begin
                busy_reg <= 1'b0;
            end
            mul_reg    <= accept;
            launch_reg <= mul_reg;
            if (cfg_wr_en)
            begin
                tpm_reg <= cfg_wr_data;
            end
        end
    end

    // captured transaction fields and scaled period
    always_comb
    begin
        period_next = {{TPM_W{1'b0}}, ms_reg} * {{MS_W{1'b0}}, tpm_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(command);
            now_reg <= now;
            ms_reg  <= interval_ms;
            tag_reg <= tag;
        end
        if (mul_reg)
        begin
            period_reg <= period_next;
        end
    end

    always_comb
    begin
        bcast.cmd    = cmd_reg;
        bcast.now    = now_reg;
        bcast.period = period_reg;
        bcast.tag    = tag_reg;
    end

    // row of timer cells
    assign tok[0]   = launch_reg;
    assign claim[0] = 1'b0;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        tmr_tbl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok[i]),
            .claim_in  (claim[i]),
            .bcast     (bcast),
            .tok_out   (tok[i+1]),
            .claim_out (claim[i+1]),
            .cand      (cell_cand[i])
        );
    end

    // scheduler stage after the last cell
    tmr_tbl_sched u_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_in   (tok[NUM_SLOTS]),
        .claim_in (claim[NUM_SLOTS]),
        .bcast    (bcast),
        .flush    (flush),
        .cand     (sched_cand)
    );

    // merge offers: only the cell or stage holding the token offers one
    always_comb
    begin
        cand      = sched_cand;
        cand_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cell_cand[i].valid)
            begin
                cand      = cell_cand[i];
                cand_slot = SLOT_W'(i);
            end
        end
    end

    // one-deep hold so the final result can carry last
    always_comb
    begin
        emit      = hold_valid_reg && (cand.valid || flush);
        emit_last = !cand.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cand.valid)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            result_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand.valid)
        begin
            hold_kind_reg <= cand.kind;
            hold_slot_reg <= cand_slot;
            hold_tag_reg  <= cand.tag;
        end
        if (emit)
        begin
            kind_reg      <= hold_kind_reg;
            slot_reg      <= hold_slot_reg;
            fired_tag_reg <= hold_tag_reg;
            last_reg      <= emit_last;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign fired_tag    = fired_tag_reg;
    assign last         = last_reg;

endmodule : timer_table_with_scheduler_tick_top
`default_nettype wire

### sv/tmr_tbl_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmr_tbl_chk
// Port-level checks on the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module tmr_tbl_chk
    import tmr_tbl_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       result_valid,
    input wire logic [2:0] kind,
    input wire logic       last
);

    // a taken start makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start");

    // nothing follows the final result of a transaction at once
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result straight after last");

    // add and install answer with a single result
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_ASSIGNED || kind == KIND_FULL
                         || kind == KIND_INSTALLED) |-> last)
        else $error("single-result transaction not marked last");

    // a scheduler fire always closes a tick
    a_sched_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_SCHED |-> last)
        else $error("scheduler result not last");

    // no result code outside the defined set
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> kind <= KIND_INSTALLED)
        else $error("undefined result kind");

endmodule : tmr_tbl_chk

bind timer_table_with_scheduler_tick_top tmr_tbl_chk u_tmr_tbl_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .last         (last)
);
`default_nettype wire

### tb/tb_timer_event_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_event_check
// Watches the command and result channels of the timer table, keeps its own
// copy of the slot table, scheduler and rate register, forecasts the results
// of every accepted command and compares each strobed result in order.
// ----------------------------------------------------------------------------
module tb_timer_event_check
    import tmr_tbl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       command,
    input  logic [NOW_W-1:0] now,
    input  logic [MS_W-1:0]  interval_ms,
    input  logic [TAG_W-1:0] tag,
    input  logic             cfg_wr_en,
    input  logic [TPM_W-1:0] cfg_wr_data,
    input  logic             result_valid,
    input  logic [2:0]       kind,
    input  logic [3:0]       slot,
    input  logic [TAG_W-1:0] fired_tag,
    input  logic             last,
    output int               errors,
    output int               outstanding
);

    localparam int SLOT_W   = $clog2(TT_NUM_SLOTS);

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } timer_event_t;

    // results still owed by the block, oldest first
    timer_event_t due_events[$];

    // own copy of the rate register, slot table and scheduler
    logic [TPM_W-1:0]    rate;
    logic [TT_NUM_SLOTS-1:0] armed;
    logic [TT_NUM_SLOTS-1:0] repeating;
    logic [NOW_W-1:0]    t_start  [TT_NUM_SLOTS];
    logic [PERIOD_W-1:0] t_period [TT_NUM_SLOTS];
    logic [TAG_W-1:0]    t_tag    [TT_NUM_SLOTS];
    logic                sched_on;
    logic [DL_W-1:0]     sched_due;
    logic [PERIOD_W-1:0] sched_every;

    function automatic timer_event_t make_event(input kind_t k, input int idx,
                                                input logic [TAG_W-1:0] who);
        timer_event_t ev;
        ev.kind = k;
        ev.slot = SLOT_W'(idx);
        ev.tag  = who;
        ev.last = 1'b0;
        return ev;
    endfunction

    // work out the results of one command and update the table copy
    task automatic forecast_events(input cmd_t op, input logic [NOW_W-1:0] at,
                                   input logic [MS_W-1:0] ms,
                                   input logic [TAG_W-1:0] who);
        logic [PERIOD_W-1:0] span;
        timer_event_t        ev;
        int                  free_idx;
        int                  count;
        span     = PERIOD_W'(ms) * PERIOD_W'(rate);
        free_idx = -1;
        count    = 0;
        case (op)
            CMD_TICK:
            begin
                // slots in index order, sums kept one bit wider
                for (int i = 0; i < TT_NUM_SLOTS; i++) begin
                    if (armed[i] &&
                        (DL_W'(t_start[i]) + DL_W'(t_period[i]) <= DL_W'(at))) begin
                        due_events.push_back(make_event(KIND_FIRED, i, t_tag[i]));
                        count++;
                        if (repeating[i])
                            t_start[i] = at;
                        else
                            armed[i] = 1'b0;
                    end
                end
                // scheduler after the slots; a carried deadline never fires
                if (sched_on && (sched_due <= DL_W'(at))) begin
                    due_events.push_back(make_event(KIND_SCHED, 0, '0));
                    count++;
                    sched_due = DL_W'(at) + DL_W'(sched_every);
                end
            end
            CMD_INSTALL:
            begin
                sched_every = span;
                sched_due   = DL_W'(at) + DL_W'(span);
                sched_on    = 1'b1;
                due_events.push_back(make_event(KIND_INSTALLED, 0, '0));
                count++;
            end
            default:
            begin
                for (int i = TT_NUM_SLOTS - 1; i >= 0; i--)
                    if (!armed[i])
                        free_idx = i;
                if (free_idx < 0) begin
                    due_events.push_back(make_event(KIND_FULL, 0, who));
                end else begin
                    armed[free_idx]     = 1'b1;
                    repeating[free_idx] = (op == CMD_ADD_PERIODIC);
                    t_start[free_idx]   = at;
                    t_period[free_idx]  = span;
                    t_tag[free_idx]     = who;
                    due_events.push_back(make_event(KIND_ASSIGNED, free_idx, who));
                end
                count++;
            end
        endcase
        // mark the final result of this command
        if (count > 0) begin
            ev      = due_events.pop_back();
            ev.last = 1'b1;
            due_events.push_back(ev);
        end
    endtask

    // monitor, predict and compare on every edge
    always @(posedge clk or negedge rst_n)
    begin
        timer_event_t want;
        if (!rst_n) begin
            rate        = TPM_RESET;
            armed       = '0;
            repeating   = '0;
            sched_on    = 1'b0;
            sched_due   = '0;
            sched_every = '0;
            due_events.delete();
            errors      = 0;
            outstanding = 0;
        end else begin
            // result strobe against the oldest expectation
            if (result_valid) begin
                if (due_events.size() == 0) begin
                    $display("%0t: unexpected result kind %0d slot %0d tag %h last %b",
                             $time, kind, slot, fired_tag, last);
                    errors++;
                end else begin
                    want = due_events.pop_front();
                    if (kind !== want.kind || slot !== want.slot ||
                        fired_tag !== want.tag || last !== want.last) begin
                        $display({"%0t: result mismatch, expected kind %0d slot %0d ",
                                  "tag %h last %b, got kind %0d slot %0d tag %h last %b"},
                                 $time, want.kind, want.slot, want.tag, want.last,
                                 kind, slot, fired_tag, last);
                        errors++;
                    end
                end
            end
            // rate register write
            if (cfg_wr_en)
                rate = cfg_wr_data;
            // accepted command transaction
            if (start && !busy)
                forecast_events(cmd_t'(command), now, interval_ms, tag);
            outstanding = due_events.size();
        end
    end

endmodule : tb_timer_event_check

### tb/tb_timer_table_with_scheduler_tick_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_table_with_scheduler_tick_top
// Drives command transactions into the timer table under a series of rate
// settings, with random gaps, and reports the verdict of the event checker.
// ----------------------------------------------------------------------------
module tb_timer_table_with_scheduler_tick_top;
    import tmr_tbl_pkg::*;

    localparam int               STALL_LIMIT = 1000;
    localparam int               SETTLE      = 24;
    localparam logic [NOW_W-1:0] TIME_MAX    = '1;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       command;
    logic [NOW_W-1:0] now;
    logic [MS_W-1:0]  interval_ms;
    logic [TAG_W-1:0] tag;
    logic             cfg_wr_en;
    logic [TPM_W-1:0] cfg_wr_data;
    logic             result_valid;
    logic [2:0]       kind;
    logic [3:0]       slot;
    logic [TAG_W-1:0] fired_tag;
    logic             last;
    int               errors;
    int               outstanding;

    // stimulus state
    logic [NOW_W-1:0] clock_t;
    int unsigned      rate_now;
    int               periodic_left;
    bit               steady;
    int               stall_cycles;

    timer_table_with_scheduler_tick_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .now          (now),
        .interval_ms  (interval_ms),
        .tag          (tag),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .kind         (kind),
        .slot         (slot),
        .fired_tag    (fired_tag),
        .last         (last)
    );

    tb_timer_event_check u_event_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .now          (now),
        .interval_ms  (interval_ms),
        .tag          (tag),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .kind         (kind),
        .slot         (slot),
        .fired_tag    (fired_tag),
        .last         (last),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_timer_table_with_scheduler_tick_top NOT OK");
                $finish;
            end
        end
    end

    // one command transaction, after random idle cycles unless steady is set
    task automatic send_item(input cmd_t op, input logic [NOW_W-1:0] at,
                             input logic [MS_W-1:0] ms, input logic [TAG_W-1:0] who);
        while (!steady && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= op;
        now         <= at;
        interval_ms <= ms;
        tag         <= who;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // rate register write once the block has drained
    task automatic set_rate(input int unsigned value);
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0 || busy);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= TPM_W'(value);
        rate_now = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random command: mostly in-order time, some commands stamped in the past
    task automatic random_item(input int tick_pct, input int stale_pct);
        cmd_t             op;
        logic [NOW_W-1:0] at;
        logic [MS_W-1:0]  ms;
        logic [63:0]      wide;
        int unsigned      unit;
        unit = (rate_now == 0) ? 1 : rate_now;
        ms   = MS_W'($urandom_range(0, 6));
        if ($urandom_range(99) < tick_pct) begin
            op   = CMD_TICK;
            wide = 64'(clock_t) + 64'(unit) * $urandom_range(0, 4) + $urandom_range(0, unit);
            clock_t = (wide > 64'(TIME_MAX)) ? TIME_MAX : wide[NOW_W-1:0];
        end else if ($urandom_range(99) < 12) begin
            op = CMD_INSTALL;
            ms = MS_W'($urandom_range(0, 8));
        end else if ($urandom_range(99) < 25 && periodic_left > 0) begin
            op = CMD_ADD_PERIODIC;
            periodic_left--;
        end else begin
            op = CMD_ADD_ONCE;
        end
        at = clock_t;
        if (op != CMD_TICK && $urandom_range(99) < stale_pct) begin
            wide = {$urandom, $urandom};
            at   = NOW_W'(wide % (64'(clock_t) + 64'd1));
            if ($urandom_range(3) == 0)
                ms = MS_W'($urandom);
        end
        send_item(op, at, ms, TAG_W'($urandom));
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        command       <= CMD_TICK;
        now           <= '0;
        interval_ms   <= '0;
        tag           <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        clock_t       = '0;
        rate_now      = 1000;
        periodic_left = 10;
        steady        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: quiet tick, both add kinds, install, due and periodic reload
        send_item(CMD_TICK, 48'd0, 24'd0, 16'h0000);
        send_item(CMD_ADD_ONCE, 48'd0, 24'd0, 16'hFFFF);
        send_item(CMD_ADD_PERIODIC, 48'd0, 24'd1, 16'h0000);
        periodic_left--;
        send_item(CMD_INSTALL, 48'd0, 24'd2, 16'h0000);
        send_item(CMD_TICK, 48'd999, 24'd0, 16'h0000);
        send_item(CMD_TICK, 48'd1000, 24'd0, 16'h0000);
        send_item(CMD_TICK, 48'd2000, 24'd0, 16'h0000);
        send_item(CMD_ADD_ONCE, 48'd2000, 24'hFFFFFF, 16'hA5A5);
        clock_t = 48'd2000;

        // zero rate: every armed slot is due on each tick
        set_rate(0);
        repeat (40) random_item(40, 5);

        set_rate(1);
        repeat (126) random_item(45, 5);

        // widest rate, back-to-back commands
        set_rate(20'hFFFFF);
        steady = 1'b1;
        repeat (60) random_item(40, 5);
        steady = 1'b0;

        // few ticks so the table fills up
        set_rate($urandom_range(1, 20'hFFFFF));
        repeat (80) random_item(15, 8);

        set_rate(3);
        clock_t = clock_t + NOW_W'({$urandom, 16'h0000});
        repeat (80) random_item(50, 6);

        // near the top of the time range
        set_rate(1000);
        clock_t = 48'hFFFF_F000_0000;
        repeat (60) random_item(40, 10);

        // directed: carried deadline, reinstall, add at the time limit
        send_item(CMD_INSTALL, TIME_MAX, 24'hFFFFFF, 16'h0000);
        send_item(CMD_TICK, TIME_MAX, 24'd0, 16'h0000);
        send_item(CMD_ADD_ONCE, TIME_MAX, 24'hFFFFFF, 16'h1234);
        send_item(CMD_INSTALL, TIME_MAX, 24'd0, 16'h0000);
        send_item(CMD_TICK, TIME_MAX, 24'd0, 16'h0000);
        send_item(CMD_TICK, TIME_MAX, 24'd0, 16'h0000);
        start <= 1'b0;

        // drain, then allow the last walk through the row to finish
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (2 * SETTLE) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_timer_table_with_scheduler_tick_top OK");
        else
            $display("tb_timer_table_with_scheduler_tick_top NOT OK");
        $finish;
    end

endmodule : tb_timer_table_with_scheduler_tick_top

### sim.f
sv/tmr_tbl_pkg.sv
sv/tmr_tbl_cell.sv
sv/tmr_tbl_sched.sv
sv/timer_table_with_scheduler_tick_top.sv
sv/tmr_tbl_chk.sv
tb/tb_timer_event_check.sv
tb/tb_timer_table_with_scheduler_tick_top.sv
